FILE: hdl/bcu_pkg.sv
// Package for the binomial coefficient unit: payload types, status codes, sequencer states.
package bcu_pkg;

  // Largest row handled; larger rows are clamped to it
  localparam int unsigned MAX_ROW = 127;

  // Field widths
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned COEFF_W = 63;
  localparam int unsigned MULT_W  = COEFF_W + ROW_W;

  // Largest coefficient that fits a signed 64-bit value
  localparam logic [COEFF_W-1:0] COEFF_LIMIT = {COEFF_W{1'b1}};

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [ROW_W-1:0] row_n;
    logic [ROW_W-1:0] pos_k;
  } bcu_in_t;

  typedef struct packed {
    logic [COEFF_W-1:0] coeff;
    logic [1:0]         status;
  } bcu_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_DONE
  } bcu_state_t;

endpackage

FILE: hdl/binomial_coefficient_unit.sv
// Binomial coefficient unit: C(n,k) by multiply-then-exact-divide recurrence.
//
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_ready   bcu_in_t  {row_n, pos_k}
// out_      output     out_valid / out_ready bcu_out_t {coeff, status}
//
// Each recurrence step is a check, one 63x7 multiply, and a 70-bit
// restoring divide (one quotient bit per cycle through a shared
// 8-bit subtract/compare). An item runs n-k steps; a k greater than n
// goes straight to the done state. The unit holds in_ready low
// while working and accepts the next item once its result is in the output
// register, even if that result is still stalled. Reset is synchronous and
// clears only the sequencer and the output valid.
module binomial_coefficient_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  bcu_pkg::bcu_in_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output bcu_pkg::bcu_out_t out_data
);
  import bcu_pkg::*;

  localparam int unsigned CNT_W = $clog2(MULT_W);

  bcu_state_t         state_r, state_nxt;
  logic [ROW_W:0]     m_r, m_nxt;       // multiplier m, one bit wider for k+1
  logic [ROW_W:0]     n_r, n_nxt;
  logic [ROW_W-1:0]   d_r, d_nxt;       // divisor m-k
  logic [COEFF_W-1:0] c_r, c_nxt;       // running coefficient
  logic [1:0]         st_r, st_nxt;
  logic [MULT_W-1:0]  quo_r, quo_nxt;   // dividend shifting out, quotient in
  logic [ROW_W-1:0]   rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  bcu_out_t           out_data_r, out_data_nxt;

  logic [ROW_W-1:0]   n_clamp;
  logic [ROW_W:0]     trial;
  logic               take;
  logic [ROW_W:0]     trial_diff;
  logic [MULT_W-1:0]  quo_step;
  logic [ROW_W-1:0]   rem_step;

  // Clamp the row to the largest supported one
  always_comb begin
    if (int'(in_data.row_n) > int'(MAX_ROW)) begin
      n_clamp = ROW_W'(MAX_ROW);
    end else begin
      n_clamp = in_data.row_n;
    end
  end

  // Shared divide step: shift one dividend bit into the remainder, try subtract
  always_comb begin
    trial      = {rem_r, quo_r[MULT_W-1]};
    trial_diff = trial - {1'b0, d_r};
    take       = (trial >= {1'b0, d_r});
    rem_step   = take ? trial_diff[ROW_W-1:0] : trial[ROW_W-1:0];
    quo_step   = {quo_r[MULT_W-2:0], take};
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    c_nxt         = c_r;
    st_nxt        = st_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the output once the transfer completes
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          n_nxt = {1'b0, n_clamp};
          m_nxt = {1'b0, in_data.pos_k} + 1'b1;
          d_nxt = ROW_W'(1);
          if (in_data.pos_k > n_clamp) begin
            c_nxt     = '0;
            st_nxt    = ST_RANGE;
            state_nxt = S_DONE;
          end else begin
            c_nxt     = COEFF_W'(1);
            st_nxt    = ST_OK;
            state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (m_r > n_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Form the full product so no high bits are lost
        quo_nxt   = {{ROW_W{1'b0}}, c_r} * MULT_W'(m_r[ROW_W-1:0]);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MULT_W - 1)) begin
          // Quotient is final: saturate if it no longer fits, else advance m
          if (quo_step[MULT_W-1:COEFF_W] != '0) begin
            c_nxt     = COEFF_LIMIT;
            st_nxt    = ST_OVF;
            state_nxt = S_DONE;
          end else begin
            c_nxt     = quo_step[COEFF_W-1:0];
            m_nxt     = m_r + 1'b1;
            d_nxt     = d_r + 1'b1;
            state_nxt = S_CHECK;
          end
        end
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.coeff  = c_r;
          out_data_nxt.status = st_r;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    n_r        <= n_nxt;
    d_r        <= d_nxt;
    c_r        <= c_nxt;
    st_r       <= st_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A k greater than n always yields a zero coefficient
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_RANGE) |-> out_data.coeff == '0)
    else $error("range status with nonzero coefficient");

  // Saturated results carry the limit value
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_OVF) |-> out_data.coeff == COEFF_LIMIT)
    else $error("overflow status without saturated coefficient");

  // Remainder stays below the divisor throughout the divide
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < d_r) && (d_r != '0))
    else $error("divider remainder out of range");

  // An accepted item starts the sequencer
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (state_r == S_CHECK) || (state_r == S_DONE))
    else $error("accepted item did not start the sequencer");

endmodule
